// ===== src/fan_tachometer_rpm_defines.svh =====
// Assertion macros shared by the fan tachometer checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FAN_TACHOMETER_RPM_DEFINES_SVH
`define FAN_TACHOMETER_RPM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/fantach_pkg.sv =====
// Package for the fan tachometer: widths, constants, state encoding and
// the request bundle sent to the serial divider. No dependencies.
package fantach_pkg;

  parameter int CHAN_W    = 2;
  parameter int CAP_W     = 16;
  parameter int OVF_W     = 8;
  parameter int RPM_W     = 23;
  parameter int QUO_W     = 24;
  parameter int DIV_STEPS = 24;
  parameter int DIV_CNT_W = 5;
  parameter int ADDR_W    = 3;
  parameter int DATA_W    = 32;

  parameter logic [QUO_W-1:0] RPM_NUM         = 24'd10000000;
  parameter logic [OVF_W-1:0] OVF_CAP         = 8'd254;
  parameter logic [OVF_W-1:0] NO_SIGNAL_RESET = 8'd2;

  // floor(x * 60 / 100) = floor(3x / 5); the divide by five is a multiply by
  // ceil(2^27 / 5) and a shift, exact for every 3x below 2^26.
  parameter int Q3_W        = 26;
  parameter int SCALE_MUL_W = 25;
  parameter int SCALE_SHIFT = 27;
  parameter int PROD_W      = 51;
  parameter logic [SCALE_MUL_W-1:0] SCALE_MUL = 25'd26843546;

  parameter logic FUNC_EDGE = 1'b0;
  parameter logic FUNC_TICK = 1'b1;

  // Register index decoded from paddr[ADDR_W-1:2].
  parameter logic REG_NO_SIGNAL_OVF = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_SCALE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             start;
    logic [CAP_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== src/fantach_div.sv =====
// Bit-serial restoring divider: 10000000 / divisor, one quotient bit a cycle.
// Depends on fantach_pkg.
module fantach_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fantach_pkg::div_req_t             req,
  output logic                              done,
  output logic [fantach_pkg::QUO_W-1:0]     quotient
);

  logic [fantach_pkg::QUO_W-1:0]     quo_r;
  logic [fantach_pkg::CAP_W-1:0]     rem_r;
  logic [fantach_pkg::CAP_W-1:0]     div_r;
  logic [fantach_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                              busy_r;
  logic                              done_r;

  logic [fantach_pkg::CAP_W:0]   rem_sh;
  logic [fantach_pkg::CAP_W+1:0] diff;
  logic                          fits;

  // The dividend shifts out of the top of quo_r while quotient bits enter below.
  assign rem_sh = {rem_r, quo_r[fantach_pkg::QUO_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, div_r};
  assign fits   = !diff[fantach_pkg::CAP_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= fantach_pkg::DIV_CNT_W'(fantach_pkg::DIV_STEPS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - fantach_pkg::DIV_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= fantach_pkg::RPM_NUM;
      rem_r <= '0;
      div_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[fantach_pkg::CAP_W-1:0] : rem_sh[fantach_pkg::CAP_W-1:0];
      quo_r <= {quo_r[fantach_pkg::QUO_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== src/fan_tachometer_rpm.sv =====
// Fan tachometer top level: per-channel capture state, control sequencer and APB register.
// Depends on fantach_pkg and fantach_div.
//
// Each input transfer is either a capture edge for one channel or an overflow tick for all
// channels, and produces exactly one result transfer reporting the named channel. Every other
// edge of a channel is captured (two pulses per revolution); the speed is
// floor(floor(10000000 / period) * 60 / 100) with period the 16-bit difference of the last two
// captures, and no_signal is set with rpm 0 when the channel's overflow count has reached the
// no_signal_overflows register (byte address 0, reset 2), when the period is zero, or when the
// channel is not implemented. One item is processed at a time: an item that needs a division
// runs through the 24-step bit-serial divider and then the scaling step, while a no-signal
// item skips both. The result sits in an output register, so the next input is accepted
// while a result waits to be taken. Write no_signal_overflows only while the block is idle.
module fan_tachometer_rpm #(
  parameter int CHANNELS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic [fantach_pkg::CHAN_W-1:0]      in_channel,
  input  logic [fantach_pkg::CAP_W-1:0]       in_capture_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fantach_pkg::CHAN_W-1:0]      out_report_channel,
  output logic [fantach_pkg::RPM_W-1:0]       out_rpm,
  output logic                                out_no_signal,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fantach_pkg::ADDR_W-1:0]      paddr,
  input  logic [fantach_pkg::DATA_W-1:0]      pwdata,
  output logic [fantach_pkg::DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Per-channel state.
  logic                            skip_r   [CHANNELS];
  logic [fantach_pkg::CAP_W-1:0]   now_r    [CHANNELS];
  logic [fantach_pkg::CAP_W-1:0]   before_r [CHANNELS];
  logic [fantach_pkg::OVF_W-1:0]   ovf_r    [CHANNELS];

  logic [fantach_pkg::OVF_W-1:0]   thr_r;
  fantach_pkg::state_t             state_r, state_nxt;

  logic [fantach_pkg::CHAN_W-1:0]  ch_r;
  logic [CH_W-1:0]                 idx_r;
  logic                            ch_ok_r;
  logic                            res_nosig_r;
  logic [fantach_pkg::PROD_W-1:0]  prod_r;

  logic                            out_valid_r;
  logic [fantach_pkg::CHAN_W-1:0]  out_ch_r;
  logic [fantach_pkg::RPM_W-1:0]   out_rpm_r;
  logic                            out_nosig_r;

  logic                            in_xfer;
  logic                            in_ch_ok;
  logic [CH_W-1:0]                 in_idx;
  logic                            cfg_wr;
  logic                            cfg_hit;

  logic [fantach_pkg::CAP_W-1:0]   period;
  logic                            no_sig;
  logic                            out_load;
  fantach_pkg::div_req_t           div_req;
  logic                            div_done;
  logic [fantach_pkg::QUO_W-1:0]   quotient;
  logic [fantach_pkg::Q3_W-1:0]    q3;
  logic [fantach_pkg::PROD_W-1:0]  prod_nxt;
  logic [fantach_pkg::RPM_W-1:0]   rpm_calc;

  assign in_xfer  = in_valid && in_ready;
  assign in_ch_ok = int'(in_channel) < CHANNELS;
  assign in_idx   = CH_W'(in_channel);

  // ---------------- configuration register ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_hit = paddr[fantach_pkg::ADDR_W-1:2] == fantach_pkg::REG_NO_SIGNAL_OVF;
  assign prdata  = cfg_hit ? {{(fantach_pkg::DATA_W - fantach_pkg::OVF_W){1'b0}}, thr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= fantach_pkg::NO_SIGNAL_RESET;
    end else if (cfg_wr && cfg_hit) begin
      thr_r <= pwdata[fantach_pkg::OVF_W-1:0];
    end
  end

  // ---------------- channel state update on input transfer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        skip_r[i]   <= 1'b0;
        now_r[i]    <= '0;
        before_r[i] <= '0;
        ovf_r[i]    <= '0;
      end
    end else if (in_xfer) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (in_func == fantach_pkg::FUNC_TICK) begin
          if (ovf_r[i] < fantach_pkg::OVF_CAP) begin
            ovf_r[i] <= ovf_r[i] + fantach_pkg::OVF_W'(1);
          end
        end else if (in_ch_ok && in_idx == CH_W'(i)) begin
          ovf_r[i]  <= '0;
          skip_r[i] <= !skip_r[i];
          if (!skip_r[i]) begin
            before_r[i] <= now_r[i];
            now_r[i]    <= in_capture_value;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ch_r    <= in_channel;
      idx_r   <= in_idx;
      ch_ok_r <= in_ch_ok;
    end
  end

  // ---------------- report evaluation ----------------
  // An unimplemented channel forces no_sig before the array lookups matter.
  assign period = now_r[idx_r] - before_r[idx_r];
  assign no_sig = !ch_ok_r || (ovf_r[idx_r] >= thr_r) || (period == '0);

  fantach_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (quotient)
  );

  assign q3       = {1'b0, quotient, 1'b0} + {2'b00, quotient};
  assign prod_nxt = fantach_pkg::PROD_W'(q3) * fantach_pkg::PROD_W'(fantach_pkg::SCALE_MUL);
  assign rpm_calc = prod_r[fantach_pkg::SCALE_SHIFT + fantach_pkg::RPM_W - 1 :
                           fantach_pkg::SCALE_SHIFT];

  always_ff @(posedge clk) begin
    if (state_r == fantach_pkg::ST_SETUP) begin
      res_nosig_r <= no_sig;
    end
    if (state_r == fantach_pkg::ST_SCALE) begin
      prod_r <= prod_nxt;
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fantach_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fantach_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = fantach_pkg::ST_SETUP;
      end
      fantach_pkg::ST_SETUP: begin
        state_nxt = no_sig ? fantach_pkg::ST_FINISH : fantach_pkg::ST_DIV;
      end
      fantach_pkg::ST_DIV: begin
        if (div_done) state_nxt = fantach_pkg::ST_SCALE;
      end
      fantach_pkg::ST_SCALE: begin
        state_nxt = fantach_pkg::ST_FINISH;
      end
      fantach_pkg::ST_FINISH: begin
        if (out_load) state_nxt = fantach_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = fantach_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    div_req.start   = 1'b0;
    div_req.divisor = period;
    out_load        = 1'b0;
    unique case (state_r)
      fantach_pkg::ST_IDLE:   in_ready      = 1'b1;
      fantach_pkg::ST_SETUP:  div_req.start = !no_sig;
      fantach_pkg::ST_FINISH: out_load      = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch_r    <= ch_r;
      out_nosig_r <= res_nosig_r;
      out_rpm_r   <= res_nosig_r ? '0 : rpm_calc;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_report_channel = out_ch_r;
  assign out_rpm            = out_rpm_r;
  assign out_no_signal      = out_nosig_r;

endmodule

// ===== src/fantach_chk.sv =====
// Port-level checker for the fan tachometer, bound to the top level.
// Depends on fantach_pkg and the macros in fan_tachometer_rpm_defines.svh.
`include "fan_tachometer_rpm_defines.svh"

module fantach_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [fantach_pkg::RPM_W-1:0]      out_rpm,
  input logic                               out_no_signal,
  input logic                               pready
);

  // A missing signal always reports zero speed.
  `FT_ASSERT_SAME(a_nosig_rpm_zero, out_valid && out_no_signal, out_rpm == '0, "no_signal with nonzero rpm")

  // A valid period always gives a speed in the nonzero range.
  `FT_ASSERT_SAME(a_rpm_range, out_valid && !out_no_signal, (out_rpm != '0) && (out_rpm <= 23'd6000000), "rpm out of range")

  // Items are processed one at a time, so input is not ready right after a transfer.
  `FT_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input ready right after a transfer")

  // A stalled result holds its value.
  `FT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_rpm) && $stable(out_no_signal), "stalled result changed")

  `FT_ASSERT_SAME(a_pready_high, 1'b1, pready, "pready deasserted")

endmodule

bind fan_tachometer_rpm fantach_chk u_fantach_chk (.*);
